FILE: sv/dht_pkg.sv
// Package for the device health tracker: codes, item types and config bundle.
package dht_pkg;

    // Event codes on the input func field
    localparam logic [2:0] FUNC_GOOD          = 3'd0;
    localparam logic [2:0] FUNC_READ_FAIL     = 3'd1;
    localparam logic [2:0] FUNC_RECOVER_CHECK = 3'd2;
    localparam logic [2:0] FUNC_ATTEMPT       = 3'd3;
    localparam logic [2:0] FUNC_RECOVER_FAIL  = 3'd4;

    // Health codes as reported on the output
    localparam logic [1:0] HEALTH_UNINIT   = 2'd0;
    localparam logic [1:0] HEALTH_NORMAL   = 2'd1;
    localparam logic [1:0] HEALTH_DEGRADED = 2'd2;
    localparam logic [1:0] HEALTH_FAILED   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_FAIL_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_RETRY_INTERVAL = 2'd1;
    localparam logic [1:0] REG_FAILURE_BUDGET = 2'd2;

    // Register reset values
    localparam logic [7:0]  FAIL_THRESHOLD_RST = 8'd3;
    localparam logic [31:0] RETRY_INTERVAL_RST = 32'd1000;
    localparam logic [31:0] FAILURE_BUDGET_RST = 32'd10000;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    // Internal health state, one-hot
    typedef enum logic [3:0] {
        HS_UNINIT   = 4'b0001,
        HS_NORMAL   = 4'b0010,
        HS_DEGRADED = 4'b0100,
        HS_FAILED   = 4'b1000
    } t_health_state;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0] health;
        logic       recover_now;
        logic       available;
        logic       failed_flag;
        logic [7:0] fail_count;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  fail_threshold;
        logic [31:0] retry_interval_ms;
        logic [31:0] failure_budget_ms;
    } t_cfg;

endpackage

FILE: sv/dht_regs.sv
// Configuration registers behind the APB-style port.
module dht_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output dht_pkg::t_cfg     o_cfg
);

    logic [7:0]  r_fail_threshold;
    logic [31:0] r_retry_interval;
    logic [31:0] r_failure_budget;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    // Write the addressed register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_threshold <= dht_pkg::FAIL_THRESHOLD_RST;
            r_retry_interval <= dht_pkg::RETRY_INTERVAL_RST;
            r_failure_budget <= dht_pkg::FAILURE_BUDGET_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                dht_pkg::REG_FAIL_THRESHOLD: r_fail_threshold <= pwdata[7:0];
                dht_pkg::REG_RETRY_INTERVAL: r_retry_interval <= pwdata;
                dht_pkg::REG_FAILURE_BUDGET: r_failure_budget <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (reg_idx)
            dht_pkg::REG_FAIL_THRESHOLD: prdata = {24'd0, r_fail_threshold};
            dht_pkg::REG_RETRY_INTERVAL: prdata = r_retry_interval;
            dht_pkg::REG_FAILURE_BUDGET: prdata = r_failure_budget;
            default:                     prdata = 32'd0;
        endcase
    end

    assign o_cfg.fail_threshold    = r_fail_threshold;
    assign o_cfg.retry_interval_ms = r_retry_interval;
    assign o_cfg.failure_budget_ms = r_failure_budget;

endmodule

FILE: sv/dht_engine.sv
// Health state registers and the per-event update logic.
module dht_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  dht_pkg::t_in_item   i_item,
    input  dht_pkg::t_cfg       i_cfg,
    output dht_pkg::t_out_item  o_result
);

    dht_pkg::t_health_state r_state, n_state;
    logic [7:0]  r_count, n_count;
    logic [31:0] r_last_good, n_last_good;
    logic [31:0] r_last_attempt, n_last_attempt;

    logic [31:0] good_age;
    logic [31:0] attempt_age;
    logic        budget_over;
    logic [7:0]  count_inc;
    logic        rec;
    logic [1:0]  health_code;

    // Elapsed times, modulo 2^32
    assign good_age    = i_item.now_ms - r_last_good;
    assign attempt_age = i_item.now_ms - r_last_attempt;
    assign budget_over = (r_last_good != 32'd0) && (good_age >= i_cfg.failure_budget_ms);
    assign count_inc   = (r_count < dht_pkg::COUNT_MAX) ? r_count + 8'd1 : r_count;

    // Work out the next state for this event
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_last_good    = r_last_good;
        n_last_attempt = r_last_attempt;
        rec            = 1'b0;
        case (i_item.func)
            dht_pkg::FUNC_GOOD: begin
                n_state        = dht_pkg::HS_NORMAL;
                n_count        = 8'd0;
                n_last_good    = i_item.now_ms;
                n_last_attempt = 32'd0;
            end
            dht_pkg::FUNC_READ_FAIL: begin
                n_count = count_inc;
                if (count_inc >= i_cfg.fail_threshold && budget_over) begin
                    n_state = dht_pkg::HS_FAILED;
                end else begin
                    n_state = dht_pkg::HS_DEGRADED;
                end
            end
            dht_pkg::FUNC_RECOVER_CHECK: begin
                if (r_state == dht_pkg::HS_DEGRADED && r_count >= i_cfg.fail_threshold) begin
                    if (budget_over) begin
                        n_state = dht_pkg::HS_FAILED;
                    end else begin
                        rec = (r_last_attempt == 32'd0) ||
                              (attempt_age >= i_cfg.retry_interval_ms);
                    end
                end
            end
            dht_pkg::FUNC_ATTEMPT: begin
                if (r_state != dht_pkg::HS_FAILED) begin
                    n_state        = dht_pkg::HS_DEGRADED;
                    n_last_attempt = i_item.now_ms;
                end
            end
            dht_pkg::FUNC_RECOVER_FAIL: begin
                if (r_state != dht_pkg::HS_FAILED) begin
                    n_last_attempt = i_item.now_ms;
                    n_state = budget_over ? dht_pkg::HS_FAILED : dht_pkg::HS_DEGRADED;
                end
            end
            default: ;
        endcase
    end

    // Commit the update when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= dht_pkg::HS_UNINIT;
            r_count        <= 8'd0;
            r_last_good    <= 32'd0;
            r_last_attempt <= 32'd0;
        end else if (i_step) begin
            r_state        <= n_state;
            r_count        <= n_count;
            r_last_good    <= n_last_good;
            r_last_attempt <= n_last_attempt;
        end
    end

    // Map the one-hot state to the reported code
    always_comb begin
        unique case (n_state)
            dht_pkg::HS_UNINIT:   health_code = dht_pkg::HEALTH_UNINIT;
            dht_pkg::HS_NORMAL:   health_code = dht_pkg::HEALTH_NORMAL;
            dht_pkg::HS_DEGRADED: health_code = dht_pkg::HEALTH_DEGRADED;
            dht_pkg::HS_FAILED:   health_code = dht_pkg::HEALTH_FAILED;
            default:              health_code = dht_pkg::HEALTH_UNINIT;
        endcase
    end

    assign o_result.health      = health_code;
    assign o_result.recover_now = rec;
    assign o_result.available   = (n_state == dht_pkg::HS_NORMAL) ||
                                  (n_state == dht_pkg::HS_DEGRADED);
    assign o_result.failed_flag = (n_state == dht_pkg::HS_FAILED);
    assign o_result.fail_count  = n_count;

endmodule

FILE: sv/device_health_tracker.sv
// Top level of the device health tracker: input register, engine, result register.
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   i_in_data  (t_in_item)
//  output    out        o_out_valid / i_out_stall o_out_data (t_out_item)
//  config    in         psel/penable/pwrite       paddr, pwdata, prdata
//
// One event per cycle sustained while the output does not stall; an event passes through
// two registers, the input register and then the result register.
// The state update is a single subtract-and-compare per elapsed time.
// Synchronous active-low reset returns the tracker to uninitialized with all times zero.
// A stall on the output holds the result register and, once the input register is
// full, stalls the input.
module device_health_tracker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dht_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dht_pkg::t_out_item  o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    dht_pkg::t_cfg      cfg;
    dht_pkg::t_in_item  r_in_data;
    logic               r_in_valid;
    dht_pkg::t_out_item r_out_data;
    logic               r_out_valid;
    dht_pkg::t_out_item result;
    logic               advance;
    logic               step;
    logic               in_take;

    dht_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Result register frees up when empty or being taken
    assign advance    = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    dht_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_data),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register: load on transfer, drain on step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_in_data;
        end
    end

    // Result register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
